[src/msp_enc_pkg.sv]
// Package for the MSP v1 frame ring encoder: payload structs, codes, state encoding
// and the command and status groups that join the controller and the datapath.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package msp_enc_pkg;

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_DRAIN   = 2'd2
  } enc_op_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_ROOM  = 2'd1;
  localparam logic [1:0] STATUS_IGNORED  = 2'd2;
  localparam logic [1:0] STATUS_FRAME    = 2'd3;

  localparam logic [7:0] HDR_DOLLAR   = 8'h24;
  localparam logic [7:0] HDR_M        = 8'h4D;
  localparam logic [7:0] HDR_GT       = 8'h3E;
  localparam logic [7:0] CMD_RESET    = 8'd182;
  localparam logic [8:0] FRAME_EXTRA  = 9'd6;

  localparam logic [2:0] HDR_IDX_DOLLAR = 3'd0;
  localparam logic [2:0] HDR_IDX_M      = 3'd1;
  localparam logic [2:0] HDR_IDX_GT     = 3'd2;
  localparam logic [2:0] HDR_IDX_LEN    = 3'd3;
  localparam logic [2:0] HDR_IDX_CMD    = 3'd4;

  localparam logic REG_PORT_ENABLED = 1'b0;
  localparam logic REG_COMMAND_CODE = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] frame_length;
    logic [7:0] data_byte;
  } enc_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [8:0] fill_level;
  } enc_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_PAYLOAD,
    ST_CHECKSUM,
    ST_DRAIN,
    ST_RESULT
  } enc_state_t;

  typedef struct packed {
    logic       take;
    logic       set_status;
    logic [1:0] status_code;
    logic       hdr_write;
    logic [2:0] hdr_index;
    logic       payload_write;
    logic       sum_write;
    logic       drain_read;
    logic       load_result;
  } enc_cmd_t;

  typedef struct packed {
    logic frame_open;
    logic room_ok;
    logic ring_empty;
    logic len_zero;
    logic last_payload;
    logic slot_free;
  } enc_flags_t;

endpackage
`default_nettype wire

[src/msp_enc_ctrl.sv]
// Controller state machine of the MSP v1 frame ring encoder.
// It depends on msp_enc_pkg and drives the datapath through enc_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module msp_enc_ctrl
  import msp_enc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] req_op,
  input  wire logic       port_enabled,
  input  wire enc_flags_t flags,
  output enc_cmd_t        cmd
);

  enc_state_t state, state_next;
  logic [2:0] hdr_count, hdr_count_next;
  logic [1:0] verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hdr_count <= HDR_IDX_DOLLAR;
    end else begin
      state     <= state_next;
      hdr_count <= hdr_count_next;
    end
  end

  always_comb begin
    verdict = STATUS_IGNORED;
    if (port_enabled) begin
      case (req_op)
        OP_BEGIN: begin
          if (flags.frame_open) verdict = STATUS_FRAME;
          else if (!flags.room_ok) verdict = STATUS_NO_ROOM;
          else verdict = STATUS_OK;
        end
        OP_PAYLOAD: verdict = flags.frame_open ? STATUS_OK : STATUS_FRAME;
        OP_DRAIN: verdict = flags.ring_empty ? STATUS_IGNORED : STATUS_OK;
        default: verdict = STATUS_IGNORED;
      endcase
    end
  end

  always_comb begin
    state_next     = state;
    hdr_count_next = hdr_count;
    case (state)
      ST_IDLE: begin
        hdr_count_next = HDR_IDX_DOLLAR;
        if (req_valid) begin
          if (verdict != STATUS_OK) state_next = ST_RESULT;
          else if (req_op == OP_BEGIN) state_next = ST_HEADER;
          else if (req_op == OP_PAYLOAD) state_next = ST_PAYLOAD;
          else state_next = ST_DRAIN;
        end
      end
      ST_HEADER: begin
        hdr_count_next = hdr_count + 3'd1;
        if (hdr_count == HDR_IDX_CMD) begin
          state_next = flags.len_zero ? ST_CHECKSUM : ST_RESULT;
        end
      end
      ST_PAYLOAD: state_next = flags.last_payload ? ST_CHECKSUM : ST_RESULT;
      ST_CHECKSUM: state_next = ST_RESULT;
      ST_DRAIN: state_next = ST_RESULT;
      ST_RESULT: begin
        if (flags.slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.status_code = verdict;
    cmd.hdr_index   = hdr_count;
    req_stall       = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall      = 1'b0;
        cmd.take       = req_valid;
        cmd.set_status = req_valid;
      end
      ST_HEADER: cmd.hdr_write = 1'b1;
      ST_PAYLOAD: cmd.payload_write = 1'b1;
      ST_CHECKSUM: cmd.sum_write = 1'b1;
      ST_DRAIN: cmd.drain_read = 1'b1;
      ST_RESULT: cmd.load_result = flags.slot_free;
      default: req_stall = 1'b1;
    endcase
  end

`ifndef SYNTHESIS
  a_header_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEADER) |-> (hdr_count <= HDR_IDX_CMD))
    else $error("header index ran past the command byte");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |=> (state == ST_RESULT))
    else $error("drain did not end in a result");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> (state != ST_IDLE))
    else $error("accepted transaction produced no work");
`endif

endmodule
`default_nettype wire

[src/msp_enc_datapath.sv]
// Datapath of the MSP v1 frame ring encoder: ring memory, pointers, checksum,
// frame counters and the result register. It depends on msp_enc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module msp_enc_datapath
  import msp_enc_pkg::*;
#(
  parameter int RING_DEPTH = 512
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire enc_req_t   req,
  input  wire logic [7:0] command_code,
  input  wire enc_cmd_t   cmd,
  output enc_flags_t      flags,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output enc_rsp_t        rsp
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CW    = ((PTR_W > 9) ? PTR_W : 9) + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(RING_DEPTH);

  logic [7:0]       ring [RING_DEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [7:0]       checksum;
  logic [7:0]       remaining;
  logic             frame_open;
  logic [1:0]       op_q;
  logic [7:0]       len_q, data_q, cmd_q;
  logic [1:0]       status_q;
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] fill;
  logic [PTR_W:0]   fill_wide;
  logic [CW-1:0]    free_space, need_space;
  logic             mem_we;
  logic [7:0]       wr_byte;
  logic             tx_sent;

  assign fill_wide  = {1'b0, wp} + ((wp < rp) ? DEPTH_X : '0) - {1'b0, rp};
  assign fill       = fill_wide[PTR_W-1:0];
  assign free_space = CW'(PTR_LAST) - CW'(fill);
  assign need_space = CW'(req.frame_length) + CW'(FRAME_EXTRA);

  assign flags.frame_open   = frame_open;
  assign flags.room_ok      = !(free_space < need_space);
  assign flags.ring_empty   = (fill == '0);
  assign flags.len_zero     = (len_q == 8'd0);
  assign flags.last_payload = (remaining == 8'd1);
  assign flags.slot_free    = !rsp_valid || !rsp_stall;

  assign mem_we = cmd.hdr_write || cmd.payload_write || cmd.sum_write;

  always_comb begin
    wr_byte = checksum;
    if (cmd.hdr_write) begin
      case (cmd.hdr_index)
        HDR_IDX_DOLLAR: wr_byte = HDR_DOLLAR;
        HDR_IDX_M:      wr_byte = HDR_M;
        HDR_IDX_GT:     wr_byte = HDR_GT;
        HDR_IDX_LEN:    wr_byte = len_q;
        HDR_IDX_CMD:    wr_byte = cmd_q;
        default:        wr_byte = cmd_q;
      endcase
    end else if (cmd.payload_write) begin
      wr_byte = data_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring[wp] <= wr_byte;
    if (cmd.drain_read) rd_data <= ring[rp];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q   <= req.op;
      len_q  <= req.frame_length;
      data_q <= req.data_byte;
      cmd_q  <= command_code;
    end
    if (cmd.set_status) status_q <= cmd.status_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      checksum   <= 8'd0;
      remaining  <= 8'd0;
      frame_open <= 1'b0;
    end else begin
      if (mem_we) wp <= (wp == PTR_LAST) ? '0 : wp + PTR_W'(1);
      if (cmd.drain_read) rp <= (rp == PTR_LAST) ? '0 : rp + PTR_W'(1);
      if (cmd.hdr_write && cmd.hdr_index == HDR_IDX_CMD) begin
        checksum   <= len_q ^ cmd_q;
        remaining  <= len_q;
        frame_open <= (len_q != 8'd0);
      end
      if (cmd.payload_write) begin
        checksum  <= checksum ^ data_q;
        remaining <= remaining - 8'd1;
        if (remaining == 8'd1) frame_open <= 1'b0;
      end
    end
  end

  assign tx_sent = (status_q == STATUS_OK) && (op_q == OP_DRAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_result) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      rsp.status     <= status_q;
      rsp.tx_valid   <= tx_sent;
      rsp.tx_byte    <= tx_sent ? rd_data : 8'd0;
      rsp.fill_level <= 9'(fill);
    end
  end

`ifndef SYNTHESIS
  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> (remaining != 8'd0))
    else $error("open frame with no payload bytes left");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (fill != PTR_LAST))
    else $error("ring write while the ring is full");
  a_open_from_header: assert property (@(posedge clk) disable iff (rst)
    $rose(frame_open) |-> $past(cmd.hdr_write))
    else $error("frame opened without a header");
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.hdr_write, cmd.payload_write, cmd.sum_write, cmd.drain_read}))
    else $error("more than one ring access in a cycle");
`endif

endmodule
`default_nettype wire

[src/msp_frame_ring_encoder_unit.sv]
// Top level of the MSP v1 frame ring encoder: configuration registers on an APB-style
// port, with msp_enc_ctrl and msp_enc_datapath. It depends on msp_enc_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction is accepted in the idle state and its result goes to an output register;
// a refused or ignored item only yields its result, a drain reads a byte, a payload byte is
// written (with the checksum when it closes the frame), and a begin writes the five header
// bytes (with the checksum for a zero-length frame); the single write port of the ring
// memory, one byte per cycle, sets the cost of frame writes. No clearing pass runs after
// reset. Configuration registers should be written only while no transaction is in flight.
module msp_frame_ring_encoder_unit
  import msp_enc_pkg::*;
#(
  parameter int RING_DEPTH = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire enc_req_t    req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output enc_rsp_t         rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic       port_enabled;
  logic [7:0] command_code;
  logic       cfg_write;
  enc_cmd_t   cmd;
  enc_flags_t flags;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_enabled <= 1'b0;
      command_code <= CMD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_PORT_ENABLED) port_enabled <= pwdata[0];
      else command_code <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_COMMAND_CODE) ? {24'd0, command_code}
                                                  : {31'd0, port_enabled};

  msp_enc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_op       (req.op),
    .port_enabled (port_enabled),
    .flags        (flags),
    .cmd          (cmd)
  );

  msp_enc_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .command_code (command_code),
    .cmd          (cmd),
    .flags        (flags),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp)
  );

endmodule
`default_nettype wire
